[sv/prt_pkg.sv]
// Shared constants and controller/datapath interface types for the pending request tracker.
`default_nettype none

package prt_pkg;

    localparam int ENTRIES         = 8;
    localparam int DEVICE_KEY_BITS = 16;
    localparam int COMMAND_BITS    = 8;
    localparam int IDX_W           = $clog2(ENTRIES);

    // Fixed port widths
    localparam int MODE_W   = 2;
    localparam int SLOT_W   = 3;
    localparam int STATUS_W = 3;
    localparam int DEVP_W   = 16;
    localparam int CMDP_W   = 8;
    localparam int RID_W    = 32;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_ALLOC    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_COMPLETE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RELEASE  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BUSY      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNMATCHED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MISMATCH  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd5;

    // Controller to datapath
    typedef struct packed {
        logic load;      // capture the incoming request
        logic exec;      // evaluate the captured request against the table
        logic gen_step;  // one round of request ID generation
        logic publish;   // move the result into the output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic alloc_go;  // allocate found a free slot and no busy device
        logic id_free;   // current ID candidate is not held by a live slot
    } sts_t;

endpackage

`default_nettype wire

[sv/prt_datapath.sv]
// Datapath: request capture, slot table, match/search logic, ID counter and result registers.
`default_nettype none

module prt_datapath (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire prt_pkg::cmd_t            cmd,
    output prt_pkg::sts_t                 sts,
    input  wire logic [1:0]               mode,
    input  wire logic [15:0]              device_key,
    input  wire logic [7:0]               command_code,
    input  wire logic [2:0]               slot_index,
    input  wire logic                     ack_is_device_ack,
    input  wire logic                     ack_has_device,
    input  wire logic                     ack_has_request_id,
    input  wire logic [15:0]              ack_device_key,
    input  wire logic [31:0]              ack_request_id,
    output logic [2:0]                    status,
    output logic [2:0]                    result_slot,
    output logic [31:0]                   issued_request_id
);
    import prt_pkg::*;

    // Captured request
    logic [MODE_W-1:0]          mode_reg;
    logic [DEVICE_KEY_BITS-1:0] dev_reg;
    logic [COMMAND_BITS-1:0]    cmd_reg;
    logic [SLOT_W-1:0]          slot_reg;
    logic                       ack_ok_reg;
    logic [DEVICE_KEY_BITS-1:0] ack_dev_reg;
    logic [RID_W-1:0]           ack_id_reg;

    // Slot table
    logic [ENTRIES-1:0]         valid_reg;
    logic [ENTRIES-1:0]         done_reg;
    logic [RID_W-1:0]           rid_reg   [ENTRIES];
    logic [DEVICE_KEY_BITS-1:0] edev_reg  [ENTRIES];
    logic [COMMAND_BITS-1:0]    ecmd_reg  [ENTRIES];

    logic [RID_W-1:0]           id_ctr_reg;
    logic [IDX_W-1:0]           alloc_idx_reg;

    // Pending result and output register
    logic [STATUS_W-1:0]        res_status_reg;
    logic [SLOT_W-1:0]          res_slot_reg;
    logic [RID_W-1:0]           res_id_reg;
    logic [STATUS_W-1:0]        out_status_reg;
    logic [SLOT_W-1:0]          out_slot_reg;
    logic [RID_W-1:0]           out_id_reg;

    logic                       busy;
    logic                       found_free;
    logic [IDX_W-1:0]           free_idx;
    logic                       match;
    logic [IDX_W-1:0]           match_idx;
    logic [RID_W-1:0]           next_id;
    logic                       id_in_use;
    logic                       ack_invalid;
    logic                       rel_in_range;

    // Table searches: independent per-slot compares, lowest index wins
    always_comb
    begin
        busy       = 1'b0;
        found_free = 1'b0;
        free_idx   = '0;
        match      = 1'b0;
        match_idx  = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (valid_reg[i] && edev_reg[i] == dev_reg)
                busy = 1'b1;
            if (!valid_reg[i] && !found_free)
            begin
                found_free = 1'b1;
                free_idx   = IDX_W'(i);
            end
            if (valid_reg[i] && !done_reg[i] && edev_reg[i] == dev_reg &&
                ack_dev_reg == dev_reg && rid_reg[i] == ack_id_reg && !match)
            begin
                match     = 1'b1;
                match_idx = IDX_W'(i);
            end
        end
    end

    // Next ID candidate skips zero; checked against every live slot
    always_comb
    begin
        next_id = id_ctr_reg + RID_W'(1);
        if (next_id == '0)
            next_id = RID_W'(1);
        id_in_use = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (valid_reg[i] && rid_reg[i] == next_id)
                id_in_use = 1'b1;
        end
    end

    assign ack_invalid  = (dev_reg == '0) || !ack_ok_reg || (ack_id_reg == '0);
    assign rel_in_range = (int'(slot_reg) < ENTRIES);

    assign sts.alloc_go = (mode_reg == MODE_ALLOC) && !busy && found_free;
    assign sts.id_free  = !id_in_use;

    // Request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg    <= mode;
            dev_reg     <= device_key[DEVICE_KEY_BITS-1:0];
            cmd_reg     <= command_code[COMMAND_BITS-1:0];
            slot_reg    <= slot_index;
            ack_ok_reg  <= ack_is_device_ack && ack_has_device && ack_has_request_id;
            ack_dev_reg <= ack_device_key[DEVICE_KEY_BITS-1:0];
            ack_id_reg  <= ack_request_id;
        end
    end

    // Control state of the table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            done_reg   <= '0;
            id_ctr_reg <= '0;
        end
        else
        begin
            if (cmd.exec)
            begin
                if (mode_reg == MODE_COMPLETE && !ack_invalid && match &&
                    ecmd_reg[match_idx] == cmd_reg)
                    done_reg[match_idx] <= 1'b1;
                if (mode_reg == MODE_RELEASE && rel_in_range)
                begin
                    valid_reg[IDX_W'(slot_reg)] <= 1'b0;
                    done_reg[IDX_W'(slot_reg)]  <= 1'b0;
                end
            end
            if (cmd.gen_step)
            begin
                id_ctr_reg <= next_id;
                if (!id_in_use)
                begin
                    valid_reg[alloc_idx_reg] <= 1'b1;
                    done_reg[alloc_idx_reg]  <= 1'b0;
                end
            end
        end
    end

    // Table payload, pending result and output register
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            res_id_reg   <= '0;
            res_slot_reg <= '0;
            case (mode_reg)
                MODE_ALLOC:
                begin
                    alloc_idx_reg <= free_idx;
                    if (busy)
                        res_status_reg <= ST_BUSY;
                    else
                        res_status_reg <= ST_FULL;
                end
                MODE_COMPLETE:
                begin
                    if (ack_invalid)
                        res_status_reg <= ST_INVALID;
                    else if (!match)
                        res_status_reg <= ST_UNMATCHED;
                    else
                    begin
                        res_slot_reg <= SLOT_W'(match_idx);
                        if (ecmd_reg[match_idx] == cmd_reg)
                            res_status_reg <= ST_OK;
                        else
                            res_status_reg <= ST_MISMATCH;
                    end
                end
                MODE_RELEASE:
                begin
                    if (rel_in_range)
                    begin
                        res_status_reg <= ST_OK;
                        res_slot_reg   <= slot_reg;
                    end
                    else
                        res_status_reg <= ST_UNMATCHED;
                end
                default:
                    res_status_reg <= ST_INVALID;
            endcase
        end
        if (cmd.gen_step && !id_in_use)
        begin
            rid_reg[alloc_idx_reg]  <= next_id;
            edev_reg[alloc_idx_reg] <= dev_reg;
            ecmd_reg[alloc_idx_reg] <= cmd_reg;
            res_status_reg          <= ST_OK;
            res_slot_reg            <= SLOT_W'(alloc_idx_reg);
            res_id_reg              <= next_id;
        end
        if (cmd.publish)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_id_reg     <= res_id_reg;
        end
    end

    assign status            = out_status_reg;
    assign result_slot       = out_slot_reg;
    assign issued_request_id = out_id_reg;

endmodule

`default_nettype wire

[sv/prt_ctrl.sv]
// Controller: sequences one request through capture, table evaluation, ID search and output.
`default_nettype none

module prt_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  wire logic          out_stall,
    output prt_pkg::cmd_t      cmd,
    input  wire prt_pkg::sts_t sts
);
    import prt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_EXEC    = 4'b0010,
        S_GENID   = 4'b0100,
        S_PUBLISH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (sts.alloc_go)
                    state_next = S_GENID;
                else
                    state_next = S_PUBLISH;
            end
            S_GENID:
            begin
                cmd.gen_step = 1'b1;
                if (sts.id_free)
                    state_next = S_PUBLISH;
            end
            S_PUBLISH:
            begin
                if (out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.publish)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

[sv/pending_request_tracker.sv]
// Top level of the pending request tracker: controller plus table datapath.
// Busy, full, complete, release and unused-mode requests pass through capture,
// table evaluation and output load; allocate adds the request ID search before
// the output load, one candidate per cycle against all live slots.
// Requests are taken one at a time: in_stall stays high until the controller is idle.
// Reset: asynchronous active low; empties all slots and zeroes the ID counter.
`default_nettype none

module pending_request_tracker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  mode,
    input  wire logic [15:0] device_key,
    input  wire logic [7:0]  command_code,
    input  wire logic [2:0]  slot_index,
    input  wire logic        ack_is_device_ack,
    input  wire logic        ack_has_device,
    input  wire logic        ack_has_request_id,
    input  wire logic [15:0] ack_device_key,
    input  wire logic [31:0] ack_request_id,
    // result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       status,
    output logic [2:0]       result_slot,
    output logic [31:0]      issued_request_id
);
    import prt_pkg::*;

    // The controller walks each request through capture, table evaluation,
    // optional ID search (allocate only) and a load into the output register.
    // The output register lets a finished result wait on a stalled consumer
    // while the controller returns to idle for the next request.
    cmd_t cmd;
    sts_t sts;

    prt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // The datapath holds the slot table (valid/done flags in reset flops,
    // IDs, device keys and commands), the ID counter, and the per-slot
    // compare trees for busy detection, free slot search, ack matching and
    // ID collision checks.
    prt_datapath u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .sts                (sts),
        .mode               (mode),
        .device_key         (device_key),
        .command_code       (command_code),
        .slot_index         (slot_index),
        .ack_is_device_ack  (ack_is_device_ack),
        .ack_has_device     (ack_has_device),
        .ack_has_request_id (ack_has_request_id),
        .ack_device_key     (ack_device_key),
        .ack_request_id     (ack_request_id),
        .status             (status),
        .result_slot        (result_slot),
        .issued_request_id  (issued_request_id)
    );

endmodule

`default_nettype wire
